// ===== hw/rtl/gri_pkg.sv =====
// ----------------------------------------------------------------------------
// gri_pkg
// Shared constants for the gyro rate integrator: fixed field widths,
// configuration register indexes, register reset values and the idle limit.
// ----------------------------------------------------------------------------
package gri_pkg;

    // fixed field widths
    localparam int DRIFT_BITS = 32;
    localparam int LIMIT_BITS = 41;
    localparam int STEP_BITS  = 40;
    localparam int TOTAL_BITS = 64;
    localparam int IDLE_BITS  = 16;
    localparam int HOLD_BITS  = 9;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = LIMIT_BITS;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRIFT     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALARM_LOW = 2'd2;

    // register reset values
    localparam logic signed [DRIFT_BITS-1:0] DRIFT_RESET = '0;
    localparam logic signed [LIMIT_BITS-1:0] LIMIT_RESET = -41'sd9049812000;
    localparam logic                         ALARM_LOW_RESET = 1'b1;

    // idle counter saturation point
    localparam logic [IDLE_BITS-1:0] IDLE_MAX = '1;

endpackage

// ===== hw/rtl/gyro_rate_integrator_overspeed.sv =====
// ----------------------------------------------------------------------------
// gyro_rate_integrator_overspeed
// Gyro poll integrator with drift compensation and overspeed alarm hold.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one poll: the sensor's sample
//   counter and raw running gyro sum. Output channel (out_valid/out_ready)
//   returns one result per poll: new-sample flag, corrected angle step,
//   running angle total, idle poll count and buzzer state.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data);
//   index 0 drift per sample, 1 overspeed limit, 2 alarm-on-low select.
//   Write it only while no transaction is in flight.
//   Two register stages: an input register for the differences, then a
//   result register after the multiply and 64-bit accumulate. A poll moves
//   from the input register into the result register, where out_valid
//   rises. Throughput is one poll per cycle while the receiver keeps up.
//   A stalled receiver holds the result register; the input register
//   still takes one more poll, then in_ready drops until the result is taken.
//   Reset clears the previous poll, the total and the alarm, sets the idle
//   and hold counters to 1 and loads the register defaults.
// ----------------------------------------------------------------------------
module gyro_rate_integrator_overspeed #(
    parameter int HOLD_POLLS = 400,
    parameter int COUNT_BITS = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [gri_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [gri_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [COUNT_BITS-1:0]                    sample_count,
    input  logic signed [VALUE_BITS-1:0]             sample_value,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic                                     new_sample,
    output logic signed [gri_pkg::STEP_BITS-1:0]     angle_step,
    output logic signed [gri_pkg::TOTAL_BITS-1:0]    angle_total,
    output logic [gri_pkg::IDLE_BITS-1:0]            idle_polls,
    output logic                                     buzzer_on
);
    import gri_pkg::*;

    logic signed [DRIFT_BITS-1:0] drift_reg;
    logic signed [LIMIT_BITS-1:0] limit_reg;
    logic                         alarm_low_reg;

    logic                         s1_valid, s1_ready;
    logic [COUNT_BITS-1:0]        s1_nsamp;
    logic signed [VALUE_BITS-1:0] s1_diff;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drift_reg     <= DRIFT_RESET;
            limit_reg     <= LIMIT_RESET;
            alarm_low_reg <= ALARM_LOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DRIFT:     drift_reg     <= $signed(cfg_data[DRIFT_BITS-1:0]);
                CFG_LIMIT:     limit_reg     <= $signed(cfg_data[LIMIT_BITS-1:0]);
                CFG_ALARM_LOW: alarm_low_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    gri_delta #(
        .COUNT_BITS (COUNT_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_delta (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_count (sample_count),
        .sample_value (sample_value),
        .s1_ready     (s1_ready),
        .s1_valid     (s1_valid),
        .s1_nsamp     (s1_nsamp),
        .s1_diff      (s1_diff)
    );

    gri_accum #(
        .HOLD_POLLS (HOLD_POLLS),
        .COUNT_BITS (COUNT_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_accum (
        .clk              (clk),
        .rst_n            (rst_n),
        .s1_valid         (s1_valid),
        .s1_ready         (s1_ready),
        .s1_nsamp         (s1_nsamp),
        .s1_diff          (s1_diff),
        .drift_per_sample (drift_reg),
        .overspeed_limit  (limit_reg),
        .alarm_on_low     (alarm_low_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .new_sample       (new_sample),
        .angle_step       (angle_step),
        .angle_total      (angle_total),
        .idle_polls       (idle_polls),
        .buzzer_on        (buzzer_on)
    );

    // checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output can drain");

    a_result_follows_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> s1_valid)
        else $error("accepted transaction not held in input stage");

endmodule

// ===== hw/rtl/gri_delta.sv =====
// ----------------------------------------------------------------------------
// gri_delta
// Input stage: registers the new-sample count and the wrapped value
// difference against the previous poll.
// ----------------------------------------------------------------------------
module gri_delta #(
    parameter int COUNT_BITS = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [COUNT_BITS-1:0]        sample_count,
    input  logic signed [VALUE_BITS-1:0] sample_value,
    input  logic                         s1_ready,
    output logic                         s1_valid,
    output logic [COUNT_BITS-1:0]        s1_nsamp,
    output logic signed [VALUE_BITS-1:0] s1_diff
);

    logic                  s1_valid_reg, s1_valid_next;
    logic [COUNT_BITS-1:0] prev_count_reg;
    logic [VALUE_BITS-1:0] prev_value_reg;
    logic [COUNT_BITS-1:0] nsamp_reg;
    logic [VALUE_BITS-1:0] diff_reg;
    logic                  accept;

    // take a transaction when the stage is empty or drains this cycle
    assign in_ready = !s1_valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_ready)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // control and previous-poll state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            prev_count_reg <= '0;
            prev_value_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                prev_count_reg <= sample_count;
                prev_value_reg <= sample_value;
            end
        end
    end

    // differences wrap at the field widths
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nsamp_reg <= sample_count - prev_count_reg;
            diff_reg  <= sample_value - prev_value_reg;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_nsamp = nsamp_reg;
    assign s1_diff  = $signed(diff_reg);

endmodule

// ===== hw/rtl/gri_accum.sv =====
// ----------------------------------------------------------------------------
// gri_accum
// Result stage: drift correction, angle accumulation, idle counting and
// overspeed alarm hold, all registered into the result.
// ----------------------------------------------------------------------------
module gri_accum #(
    parameter int HOLD_POLLS = 400,
    parameter int COUNT_BITS = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s1_valid,
    output logic                                  s1_ready,
    input  logic [COUNT_BITS-1:0]                 s1_nsamp,
    input  logic signed [VALUE_BITS-1:0]          s1_diff,
    input  logic signed [gri_pkg::DRIFT_BITS-1:0] drift_per_sample,
    input  logic signed [gri_pkg::LIMIT_BITS-1:0] overspeed_limit,
    input  logic                                  alarm_on_low,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  new_sample,
    output logic signed [gri_pkg::STEP_BITS-1:0]  angle_step,
    output logic signed [gri_pkg::TOTAL_BITS-1:0] angle_total,
    output logic [gri_pkg::IDLE_BITS-1:0]         idle_polls,
    output logic                                  buzzer_on
);
    import gri_pkg::*;

    localparam int PROD_BITS = DRIFT_BITS + COUNT_BITS + 1;
    localparam logic [HOLD_BITS-1:0] HOLD_LAST = HOLD_BITS'(HOLD_POLLS);
    localparam logic [HOLD_BITS-1:0] HOLD_ONE  = HOLD_BITS'(1);
    localparam logic [IDLE_BITS-1:0] IDLE_ONE  = IDLE_BITS'(1);

    logic                    out_valid_reg, out_valid_next;
    logic                    new_sample_reg;
    logic [STEP_BITS-1:0]    step_reg;
    logic [TOTAL_BITS-1:0]   total_reg, total_next;
    logic [IDLE_BITS-1:0]    idle_reg, idle_next;
    logic                    alarm_reg, alarm_next;
    logic [HOLD_BITS-1:0]    hold_reg, hold_next;

    logic                    take;
    logic                    has_new;
    logic signed [PROD_BITS-1:0] prod;
    logic [TOTAL_BITS-1:0]   diff_ext, prod_ext, drift_ext, limit_ext;
    logic [TOTAL_BITS-1:0]   step, corr;
    logic                    hit;

    // handshake toward the output register
    assign s1_ready = !out_valid_reg || out_ready;
    assign take     = s1_valid && s1_ready;

    always_comb
    begin
        if (take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // drift correction
    assign has_new   = (s1_nsamp != '0);
    assign prod      = drift_per_sample * $signed({1'b0, s1_nsamp});
    assign diff_ext  = {{(TOTAL_BITS-VALUE_BITS){s1_diff[VALUE_BITS-1]}}, s1_diff};
    assign prod_ext  = {{(TOTAL_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};
    assign drift_ext = {{(TOTAL_BITS-DRIFT_BITS){drift_per_sample[DRIFT_BITS-1]}},
                        drift_per_sample};
    assign limit_ext = {{(TOTAL_BITS-LIMIT_BITS){overspeed_limit[LIMIT_BITS-1]}},
                        overspeed_limit};
    assign step      = has_new ? (diff_ext - prod_ext) : '0;
    assign corr      = diff_ext - drift_ext;

    // threshold test of the difference, corrected by one drift unit, against the limit
    always_comb
    begin
        if (alarm_on_low)
            hit = ($signed(corr) <= $signed(limit_ext));
        else
            hit = ($signed(limit_ext) <= $signed(corr));
    end

    // accumulator and idle counter
    always_comb
    begin
        total_next = total_reg + step;
        if (has_new)
            idle_next = IDLE_ONE;
        else if (idle_reg != IDLE_MAX)
            idle_next = idle_reg + IDLE_ONE;
        else
            idle_next = idle_reg;
    end

    // alarm hold: expire, advance, then retrigger
    always_comb
    begin
        hold_next  = hold_reg;
        alarm_next = alarm_reg;
        if (hold_next == HOLD_LAST)
        begin
            hold_next  = HOLD_ONE;
            alarm_next = 1'b0;
        end
        if (alarm_next)
            hold_next = hold_next + HOLD_ONE;
        if (hit)
        begin
            alarm_next = 1'b1;
            hold_next  = HOLD_ONE;
        end
    end

    // state that is also the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            idle_reg      <= IDLE_ONE;
            alarm_reg     <= 1'b0;
            hold_reg      <= HOLD_ONE;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                total_reg <= total_next;
                idle_reg  <= idle_next;
                alarm_reg <= alarm_next;
                hold_reg  <= hold_next;
            end
        end
    end

    // per-transaction result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            new_sample_reg <= has_new;
            step_reg       <= step[STEP_BITS-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign new_sample  = new_sample_reg;
    assign angle_step  = $signed(step_reg);
    assign angle_total = $signed(total_reg);
    assign idle_polls  = idle_reg;
    assign buzzer_on   = alarm_reg;

    // checks
    a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg != '0 && hold_reg <= HOLD_LAST)
        else $error("hold counter out of range");

    a_idle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        idle_reg != '0)
        else $error("idle counter reached zero");

    a_no_step_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !new_sample |-> angle_step == '0)
        else $error("nonzero step without new samples");

    a_new_resets_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_sample |-> idle_polls == IDLE_ONE)
        else $error("idle count not restarted on new sample");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for gyro_rate_integrator_overspeed. Polls of sample counter and
// raw gyro sum are pushed through the valid/ready input with random gaps.
// An in-bench integrator computes the expected step, total, idle count and
// buzzer state for every poll. Each returned result is checked in order
// against that. Directed tests cover the counter and value wraps, drift and
// limit extremes, alarm boundaries and a long idle run. Random tests cover
// sensor streams with overspeed spikes, alarm hold expiry and raw noise.
// ----------------------------------------------------------------------------
module tb_top;
    import gri_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int HOLD_POLLS = 400;
    localparam int CYCLE_LIMIT = 500000;

    // one expected result per poll
    typedef struct packed {
        logic                 new_sample;
        logic [STEP_BITS-1:0]  step;
        logic [TOTAL_BITS-1:0] total;
        logic [IDLE_BITS-1:0]  idle;
        logic                  buzzer;
    } poll_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [7:0]                sample_count = '0;
    logic [31:0]               sample_value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      new_sample;
    logic signed [STEP_BITS-1:0]  angle_step;
    logic signed [TOTAL_BITS-1:0] angle_total;
    logic [IDLE_BITS-1:0]      idle_polls;
    logic                      buzzer_on;

    // integrator copy: configuration
    logic [DRIFT_BITS-1:0]     drift_reg = DRIFT_RESET;
    logic [LIMIT_BITS-1:0]     limit_reg = LIMIT_RESET;
    logic                      alarm_low_reg = ALARM_LOW_RESET;

    // integrator copy: state
    logic [7:0]                est_prev_count = '0;
    logic [31:0]               est_prev_value = '0;
    logic [TOTAL_BITS-1:0]     est_total = '0;
    logic [IDLE_BITS-1:0]      est_idle = 16'd1;
    logic                      est_alarm = 1'b0;
    logic [HOLD_BITS-1:0]      est_hold = 9'd1;

    poll_result_t pending_results[$];
    poll_result_t due_result;

    int errors = 0;
    int polls_sent = 0;
    int results_checked = 0;
    int alarm_triggers = 0;
    int cycle_count = 0;
    bit tx_gaps_on = 1'b1;
    bit rx_stalls_on = 1'b1;
    int rx_hold_cycles = 0;

    gyro_rate_integrator_overspeed #(
        .HOLD_POLLS (HOLD_POLLS),
        .COUNT_BITS (8),
        .VALUE_BITS (32)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_count (sample_count),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .new_sample   (new_sample),
        .angle_step   (angle_step),
        .angle_total  (angle_total),
        .idle_polls   (idle_polls),
        .buzzer_on    (buzzer_on)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("[gyro_rate_integrator_overspeed] ERROR");
            $finish;
        end
    end

    // Integrate one poll: counter and value differences, drift correction,
    // accumulate, idle count, then the alarm hold sequence.
    function automatic poll_result_t integrate_poll(input logic [7:0] cnt,
                                                    input logic [31:0] val);
        poll_result_t r;
        logic [7:0]  fresh;
        logic [31:0] dv;
        logic [63:0] diff;
        logic [63:0] drift_w;
        logic [63:0] lim_w;
        logic [63:0] step;
        logic [63:0] corr;
        logic        hit;
        fresh   = cnt - est_prev_count;
        dv      = val - est_prev_value;
        diff    = {{32{dv[31]}}, dv};
        drift_w = {{32{drift_reg[31]}}, drift_reg};
        lim_w   = {{23{limit_reg[40]}}, limit_reg};
        step    = '0;
        if (fresh != 8'd0)
        begin
            step      = diff - drift_w * {56'd0, fresh};
            est_total = est_total + step;
            est_idle  = 16'd1;
        end
        else if (est_idle != IDLE_MAX)
        begin
            est_idle = est_idle + 16'd1;
        end
        est_prev_count = cnt;
        est_prev_value = val;

        // hold expiry, hold count, then (re)trigger
        if (est_hold == 9'(HOLD_POLLS))
        begin
            est_hold  = 9'd1;
            est_alarm = 1'b0;
        end
        if (est_alarm)
            est_hold = est_hold + 9'd1;
        corr = diff - drift_w;
        hit  = alarm_low_reg ? ($signed(corr) <= $signed(lim_w))
                             : ($signed(lim_w) <= $signed(corr));
        if (hit)
        begin
            est_alarm = 1'b1;
            est_hold  = 9'd1;
            alarm_triggers++;
        end

        r.new_sample = (fresh != 8'd0);
        r.step       = step[STEP_BITS-1:0];
        r.total      = est_total;
        r.idle       = est_idle;
        r.buzzer     = est_alarm;
        return r;
    endfunction

    function automatic void compare_field(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 20)
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endfunction

    // result checker: sampled at the falling edge, the handshake completes
    // at the next rising edge with these values
    always @(negedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 20)
                    $display("%0t: result transaction with no poll outstanding", $time);
            end
            else
            begin
                due_result = pending_results.pop_front();
                results_checked++;
                compare_field("new_sample", 64'(due_result.new_sample), 64'(new_sample));
                compare_field("angle_step", 64'(due_result.step),
                              64'($unsigned(angle_step)));
                compare_field("angle_total", due_result.total, angle_total);
                compare_field("idle_polls", 64'(due_result.idle), 64'(idle_polls));
                compare_field("buzzer_on", 64'(due_result.buzzer), 64'(buzzer_on));
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial
    begin : rx_driver
        int stall_len;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles != 0)
            begin
                out_ready <= 1'b0;
                stall_len = rx_hold_cycles;
                rx_hold_cycles = 0;
                repeat (stall_len) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (rx_stalls_on && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // send one poll; returns at the edge where the transaction completes
    task automatic send_poll(input logic [7:0] cnt, input logic [31:0] val);
        if (tx_gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample_count <= cnt;
        sample_value <= val;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        pending_results.push_back(integrate_poll(cnt, val));
        polls_sent++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic signed [CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_DRIFT:     drift_reg = data[DRIFT_BITS-1:0];
            CFG_LIMIT:     limit_reg = data;
            CFG_ALARM_LOW: alarm_low_reg = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Well-formed sensor stream: counter advances by 0..3, value by rate per
    // sample plus noise, with a spike on a fixed poll of each period and
    // rarely at random.
    task automatic run_sensor_stream(input int polls, input int signed rate,
                                     input int signed spike, input int period);
        logic [7:0]  cnt;
        logic [31:0] val;
        int          adv;
        int signed   delta;
        cnt = est_prev_count;
        val = est_prev_value;
        for (int i = 0; i < polls; i++)
        begin
            adv   = $urandom_range(0, 3);
            delta = rate * adv + int'($urandom_range(0, 100)) - 50;
            if ((period != 0 && i % period == 10) || $urandom_range(0, 499) == 0)
                delta = delta + spike;
            cnt = cnt + 8'(adv);
            val = val + 32'(delta);
            send_poll(cnt, val);
        end
    endtask

    // reset defaults: idle polls, counter wrap, value wrap, extreme values
    task automatic test_default_edges();
        send_poll(8'd0, 32'h0000_0000);
        send_poll(8'd0, 32'h7FFF_FFFF);
        send_poll(8'd1, 32'h8000_0000);
        send_poll(8'd0, 32'h0000_0000);
        send_poll(8'd255, 32'hFFFF_FFFF);
        send_poll(8'd255, 32'h7FFF_FFFF);
        send_poll(8'd0, 32'h7FFF_FFFF);
    endtask

    // drift at both extremes with the largest sample count
    task automatic test_drift_extremes();
        wait_drained();
        write_reg(CFG_DRIFT, 41'(32'sh8000_0000));
        send_poll(8'd255, 32'hFFFF_FFFE);
        send_poll(8'd255, 32'hFFFF_FFFE);
        wait_drained();
        write_reg(CFG_DRIFT, 41'(32'sh7FFF_FFFF));
        send_poll(8'd254, 32'h7FFF_FFFE);
        send_poll(8'd255, 32'h7FFF_FFFE);
    endtask

    // limit extremes in both directions, and the equal-to-limit boundary
    task automatic test_limit_extremes();
        wait_drained();
        write_reg(CFG_DRIFT, 41'sd0);
        write_reg(CFG_ALARM_LOW, 41'sd1);
        write_reg(CFG_LIMIT, {1'b0, {40{1'b1}}});
        send_poll(est_prev_count + 8'd1, est_prev_value + 32'd7);
        send_poll(est_prev_count, est_prev_value);
        wait_drained();
        write_reg(CFG_LIMIT, {1'b1, 40'd0});
        send_poll(est_prev_count + 8'd2, est_prev_value - 32'd9);
        wait_drained();
        write_reg(CFG_ALARM_LOW, 41'sd0);
        send_poll(est_prev_count, est_prev_value + 32'd3);
        wait_drained();
        write_reg(CFG_LIMIT, {1'b0, {40{1'b1}}});
        send_poll(est_prev_count + 8'd1, 32'h7FFF_FFFF);
        wait_drained();
        write_reg(CFG_LIMIT, -41'sd5);
        send_poll(est_prev_count, est_prev_value - 32'd5);
        wait_drained();
        write_reg(CFG_ALARM_LOW, 41'sd1);
        send_poll(est_prev_count + 8'd3, est_prev_value - 32'd5);
        send_poll(est_prev_count, est_prev_value - 32'd4);
    endtask

    // long run of idle polls at full rate, then released by a new sample
    task automatic test_idle_run();
        wait_drained();
        write_reg(CFG_LIMIT, {1'b1, 40'd0});
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (40) send_poll(est_prev_count, $urandom());
        send_poll(est_prev_count + 8'd1, $urandom());
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // negative overspeed: trigger, long receiver hold-off, hold expiry
    task automatic test_overspeed_hold();
        int signed rate;
        rate = int'($urandom_range(0, 2000)) - 1000;
        wait_drained();
        write_reg(CFG_DRIFT, 41'(rate));
        write_reg(CFG_LIMIT, -41'sd100000);
        write_reg(CFG_ALARM_LOW, 41'sd1);
        run_sensor_stream(100, rate, -300000, 450);
        rx_hold_cycles = 80;
        run_sensor_stream(450, rate, -300000, 450);
    endtask

    // positive overspeed with frequent retriggers inside the hold
    task automatic test_overspeed_high();
        int signed rate;
        rate = int'($urandom_range(0, 2000)) - 1000;
        wait_drained();
        write_reg(CFG_DRIFT, 41'(rate));
        write_reg(CFG_LIMIT, 41'sd100000);
        write_reg(CFG_ALARM_LOW, 41'sd0);
        run_sensor_stream(180, rate, 300000, 60);
    endtask

    // raw noise under a random configuration
    task automatic test_random_noise();
        int signed          drift_pick;
        logic signed [40:0] limit_pick;
        logic [7:0]         cnt;
        drift_pick = $urandom();
        limit_pick = {9'($urandom()), $urandom()};
        wait_drained();
        write_reg(CFG_DRIFT, 41'(drift_pick));
        write_reg(CFG_LIMIT, limit_pick);
        write_reg(CFG_ALARM_LOW, 41'($urandom_range(0, 1)));
        for (int i = 0; i < 130; i++)
        begin
            cnt = ($urandom_range(0, 3) == 0) ? est_prev_count : 8'($urandom());
            send_poll(cnt, $urandom());
        end
    endtask

    // closing stream at full rate on both sides
    task automatic test_steady_flow();
        int signed rate;
        rate = int'($urandom_range(0, 2000)) - 1000;
        wait_drained();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        write_reg(CFG_DRIFT, 41'(rate));
        write_reg(CFG_LIMIT, -41'sd50000);
        write_reg(CFG_ALARM_LOW, 41'sd1);
        run_sensor_stream(100, rate, -80000, 40);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_edges();
        test_drift_extremes();
        test_limit_extremes();
        test_idle_run();
        test_overspeed_hold();
        test_overspeed_high();
        test_random_noise();
        test_steady_flow();

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Covered %0d polls, %0d results checked, %0d overspeed triggers;",
                 polls_sent, results_checked, alarm_triggers);
        $display("wraps, drift and limit extremes, alarm hold, idle runs and stalls.");
        if (errors == 0)
            $display("[gyro_rate_integrator_overspeed] OK");
        else
            $display("[gyro_rate_integrator_overspeed] ERROR");
        $finish;
    end

endmodule
